// File: rtl/ptjs_pkg.sv
// Shared types, fixed-point constants and codes for the pose-to-joint smoother.
package ptjs_pkg;

   localparam int FRAC_BITS   = 12;
   localparam int ALPHA_BITS  = 12;
   localparam int NUM_JOINTS  = 6;
   localparam int NUM_POSE_MUL = 3;
   localparam int ONE_Q       = 1 << FRAC_BITS;

   // Decimal constants rounded to the nearest step of the fixed-point grid
   localparam int K_HALF_I     = (5 * ONE_Q + 5) / 10;
   localparam int K_YAW_GAIN_I = (16 * ONE_Q + 5) / 10;
   localparam int K_SH_BASE_I  = (160 * ONE_Q + 50) / 100;
   localparam int K_SH_GAIN_I  = (110 * ONE_Q + 50) / 100;
   localparam int K_EL_BASE_I  = (20 * ONE_Q + 50) / 100;
   localparam int K_EL_GAIN_I  = (75 * ONE_Q + 50) / 100;
   localparam int K_TILT_MAX_I = (12 * ONE_Q + 5) / 10;
   localparam int K_FOLD_SH_I  = (260 * ONE_Q + 50) / 100;
   localparam int K_FOLD_EL_I  = (20 * ONE_Q + 50) / 100;
   localparam int K_IDLE_SH_I  = (110 * ONE_Q + 50) / 100;
   localparam int K_IDLE_EL_I  = (60 * ONE_Q + 50) / 100;

   typedef logic signed [15:0] angle_type;
   typedef logic signed [17:0] opnd_type;
   typedef logic [2:0]         jidx_type;
   typedef logic [2:0]         step_type;
   typedef logic [12:0]        alpha_type;

   function automatic angle_type sat_k(int v);
      angle_type r;
      if (v > 32767) begin
         r = 16'sh7FFF;
      end else if (v < -32768) begin
         r = 16'sh8000;
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

   localparam angle_type K_ONE      = sat_k(ONE_Q);
   localparam angle_type K_HALF     = sat_k(K_HALF_I);
   localparam angle_type K_TILT_MAX = sat_k(K_TILT_MAX_I);
   localparam angle_type K_TILT_MIN = sat_k(-K_TILT_MAX_I);
   localparam angle_type K_SH_BASE  = sat_k(K_SH_BASE_I);
   localparam angle_type K_EL_BASE  = sat_k(-K_EL_BASE_I);
   localparam angle_type K_FOLD_SH  = sat_k(K_FOLD_SH_I);
   localparam angle_type K_FOLD_EL  = sat_k(K_FOLD_EL_I);
   localparam angle_type K_IDLE_SH  = sat_k(K_IDLE_SH_I);
   localparam angle_type K_IDLE_EL  = sat_k(-K_IDLE_EL_I);
   localparam opnd_type  K_YAW_GAIN = opnd_type'(K_YAW_GAIN_I);
   localparam opnd_type  K_SH_GAIN  = opnd_type'(K_SH_GAIN_I);
   localparam opnd_type  K_EL_GAIN  = opnd_type'(K_EL_GAIN_I);

   localparam alpha_type ALPHA_ALIVE_RST = 13'd1024;
   localparam alpha_type ALPHA_LOST_RST  = 13'd246;
   localparam logic [7:0] TIMEOUT_RST    = 8'd15;
   localparam logic [7:0] AGE_MAX        = 8'd255;

   localparam step_type TICK_STEPS = step_type'(NUM_JOINTS);
   localparam step_type POSE_STEPS = step_type'(NUM_POSE_MUL);

   localparam logic OP_POSE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam jidx_type J_YAW      = 3'd0;
   localparam jidx_type J_SHOULDER = 3'd1;
   localparam jidx_type J_ELBOW    = 3'd2;
   localparam jidx_type J_PITCH    = 3'd3;
   localparam jidx_type J_ROLL     = 3'd4;
   localparam jidx_type J_GRIP     = 3'd5;

   typedef enum logic [2:0] {
      CSR_ALPHA_ALIVE = 3'd0,
      CSR_ALPHA_LOST  = 3'd1,
      CSR_TIMEOUT     = 3'd2,
      CSR_IDLE_SH     = 3'd3,
      CSR_IDLE_EL     = 3'd4,
      CSR_IDLE_GRIP   = 3'd5
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic     tick;
      logic     issue;
      jidx_type iss_idx;
      logic     wb;
      jidx_type wb_idx;
      logic     load_rsp;
   } ctl_type;

endpackage

// File: rtl/ptjs_unit.sv
// Shared multiplier with registered product, then shift, add and 16-bit saturation.
module ptjs_unit (
   input  logic                clock,
   input  logic                issue,
   input  logic                tick,
   input  ptjs_pkg::opnd_type  mul_a,
   input  ptjs_pkg::opnd_type  mul_b,
   input  ptjs_pkg::angle_type base,
   input  logic                neg,
   output ptjs_pkg::angle_type result
);

   localparam logic signed [37:0] SAT_HI = 38'sd32767;
   localparam logic signed [37:0] SAT_LO = -38'sd32768;

   logic signed [35:0]  prod_ff;
   ptjs_pkg::angle_type base_ff;
   logic                neg_ff;
   logic                tick_ff;
   logic signed [35:0]  quot;
   logic signed [37:0]  term;
   logic signed [37:0]  sum;

   always_ff @(posedge clock) begin
      if (issue) begin
         prod_ff <= mul_a * mul_b;
         base_ff <= base;
         neg_ff  <= neg;
         tick_ff <= tick;
      end
   end

   always_comb begin
      quot = tick_ff ? (prod_ff >>> ptjs_pkg::ALPHA_BITS) : (prod_ff >>> ptjs_pkg::FRAC_BITS);
      term = neg_ff ? -38'(quot) : 38'(quot);
      sum  = 38'(base_ff) + term;
      if (sum > SAT_HI) begin
         result = 16'sh7FFF;
      end else if (sum < SAT_LO) begin
         result = 16'sh8000;
      end else begin
         result = sum[15:0];
      end
   end

endmodule

// File: rtl/ptjs_ctrl.sv
// Sequencer: steps the shared unit over the joints of one transaction.
module ptjs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              start_tick,
   input  logic              out_free,
   output logic              ready,
   output ptjs_pkg::ctl_type ctl
);

   ptjs_pkg::state_type state_ff, state_in;
   ptjs_pkg::step_type  step_ff, step_in;
   logic                tick_ff, tick_in;
   ptjs_pkg::step_type  last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptjs_pkg::ST_IDLE;
         step_ff  <= '0;
         tick_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         tick_ff  <= tick_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      tick_in      = tick_ff;
      ready        = 1'b0;
      last         = tick_ff ? ptjs_pkg::TICK_STEPS : ptjs_pkg::POSE_STEPS;
      ctl.tick     = tick_ff;
      ctl.issue    = 1'b0;
      ctl.iss_idx  = step_ff;
      ctl.wb       = 1'b0;
      ctl.wb_idx   = step_ff - 3'd1;
      ctl.load_rsp = 1'b0;
      unique case (state_ff)
         ptjs_pkg::ST_IDLE: begin
            ready = 1'b1;
            if (start) begin
               state_in = ptjs_pkg::ST_RUN;
               step_in  = '0;
               tick_in  = start_tick;
            end
         end
         ptjs_pkg::ST_RUN: begin
            // issue joint n while writing back joint n-1
            ctl.issue = (step_ff < last);
            ctl.wb    = (step_ff != 3'd0);
            step_in   = step_ff + 3'd1;
            if (step_ff == last) begin
               state_in = ptjs_pkg::ST_FINISH;
            end
         end
         ptjs_pkg::ST_FINISH: begin
            if (!tick_ff) begin
               state_in = ptjs_pkg::ST_IDLE;
            end else if (out_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = ptjs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptjs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/pose_to_joint_smoother.sv
// Top level of the pose-to-joint smoother: config, joint state, operand selection, output.
//
// Input channel req_: one transaction per item. req_tuser is the op (0 = hand pose,
// 1 = tick); req_tdata carries hand_x, hand_y, hand_tilt, hand_grip, 16 bits each.
// A pose transaction updates the target joints and produces no result. A tick
// transaction moves the six smoothed joints towards their goal and produces one
// result on rsp_, rsp_tdata holding the six joints from base_yaw up, 16 bits each.
// Configuration: csr_we writes csr_wdata to register csr_index in any cycle; write
// only while no transaction is in progress.
// Timing: one 18x18 multiplier serves all joints, one joint per cycle with the
// product registered before the add. A tick runs 6 multiplies, a drain step and a
// finish step that loads the output register and raises rsp_tvalid, req_tready
// returning in the same cycle; a pose runs its multiplies, a drain step and a finish
// step before req_tready returns. One item is in flight at a time.
// A stalled result sits in the output register while further transactions are
// accepted; a tick finishing meanwhile holds until that register is free.
// Reset (synchronous, active high) restores default registers, the idle target
// pose, the folded smoothed pose and a zero pose age, and empties the output.
module pose_to_joint_smoother (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // hand_x, hand_y, hand_tilt, hand_grip
   input  logic        req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,  // base_yaw, shoulder, elbow, wrist_pitch, wrist_roll, gripper
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   ptjs_pkg::alpha_type  alpha_alive_ff;
   ptjs_pkg::alpha_type  alpha_lost_ff;
   logic [7:0]           timeout_ff;
   ptjs_pkg::angle_type  idle_sh_ff;
   ptjs_pkg::angle_type  idle_el_ff;
   ptjs_pkg::angle_type  idle_grip_ff;

   ptjs_pkg::angle_type  target_ff [ptjs_pkg::NUM_JOINTS];
   ptjs_pkg::angle_type  smooth_ff [ptjs_pkg::NUM_JOINTS];
   logic [7:0]           age_ff;

   ptjs_pkg::opnd_type   xm_ff;
   ptjs_pkg::opnd_type   lift_ff;
   logic                 alive_ff;
   ptjs_pkg::alpha_type  alpha_ff;

   logic                 rsp_tvalid_ff;
   logic [95:0]          rsp_data_ff;

   logic                 req_acc;
   logic                 out_free;
   logic                 alive_now;
   ptjs_pkg::ctl_type    ctl;
   ptjs_pkg::angle_type  hx, hy, ht, hg;
   ptjs_pkg::angle_type  xc, yc, tc, gc;
   ptjs_pkg::angle_type  goal;
   ptjs_pkg::opnd_type   mul_a, mul_b;
   ptjs_pkg::angle_type  base;
   logic                 neg;
   ptjs_pkg::angle_type  result;

   assign req_acc   = req_tvalid && req_tready;
   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign alive_now = (age_ff < timeout_ff);

   ptjs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (req_acc),
      .start_tick (req_tuser),
      .out_free   (out_free),
      .ready      (req_tready),
      .ctl        (ctl)
   );

   ptjs_unit u_unit (
      .clock  (clock),
      .issue  (ctl.issue),
      .tick   (ctl.tick),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .base   (base),
      .neg    (neg),
      .result (result)
   );

   // clamp the hand fields
   always_comb begin
      hx = req_tdata[15:0];
      hy = req_tdata[31:16];
      ht = req_tdata[47:32];
      hg = req_tdata[63:48];
      xc = (hx < 16'sd0) ? 16'sd0 : ((hx > ptjs_pkg::K_ONE) ? ptjs_pkg::K_ONE : hx);
      yc = (hy < 16'sd0) ? 16'sd0 : ((hy > ptjs_pkg::K_ONE) ? ptjs_pkg::K_ONE : hy);
      gc = (hg < 16'sd0) ? 16'sd0 : ((hg > ptjs_pkg::K_ONE) ? ptjs_pkg::K_ONE : hg);
      tc = (ht < ptjs_pkg::K_TILT_MIN) ? ptjs_pkg::K_TILT_MIN :
           ((ht > ptjs_pkg::K_TILT_MAX) ? ptjs_pkg::K_TILT_MAX : ht);
   end

   // operand selection for the joint being issued
   always_comb begin
      case (ctl.iss_idx) inside
         ptjs_pkg::J_SHOULDER: goal = alive_ff ? target_ff[ctl.iss_idx] : idle_sh_ff;
         ptjs_pkg::J_ELBOW:    goal = alive_ff ? target_ff[ctl.iss_idx] : idle_el_ff;
         ptjs_pkg::J_GRIP:     goal = alive_ff ? target_ff[ctl.iss_idx] : idle_grip_ff;
         ptjs_pkg::J_YAW, ptjs_pkg::J_PITCH, ptjs_pkg::J_ROLL:
                               goal = alive_ff ? target_ff[ctl.iss_idx] : '0;
         default:              goal = '0;
      endcase
      mul_a = xm_ff;
      mul_b = ptjs_pkg::K_YAW_GAIN;
      base  = '0;
      neg   = 1'b0;
      if (ctl.tick) begin
         mul_a = 18'(goal) - 18'(smooth_ff[ctl.iss_idx]);
         mul_b = ptjs_pkg::opnd_type'({5'b0, alpha_ff});
         base  = smooth_ff[ctl.iss_idx];
      end else begin
         case (ctl.iss_idx)
            ptjs_pkg::J_SHOULDER: begin
               mul_a = lift_ff;
               mul_b = ptjs_pkg::K_SH_GAIN;
               base  = ptjs_pkg::K_SH_BASE;
               neg   = 1'b1;
            end
            ptjs_pkg::J_ELBOW: begin
               mul_a = lift_ff;
               mul_b = ptjs_pkg::K_EL_GAIN;
               base  = ptjs_pkg::K_EL_BASE;
               neg   = 1'b1;
            end
            default: begin
               mul_a = xm_ff;
               mul_b = ptjs_pkg::K_YAW_GAIN;
            end
         endcase
      end
   end

   // configuration, joint state and pose age
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_alive_ff <= ptjs_pkg::ALPHA_ALIVE_RST;
         alpha_lost_ff  <= ptjs_pkg::ALPHA_LOST_RST;
         timeout_ff     <= ptjs_pkg::TIMEOUT_RST;
         idle_sh_ff     <= ptjs_pkg::K_IDLE_SH;
         idle_el_ff     <= ptjs_pkg::K_IDLE_EL;
         idle_grip_ff   <= ptjs_pkg::K_HALF;
         target_ff[ptjs_pkg::J_YAW]      <= '0;
         target_ff[ptjs_pkg::J_SHOULDER] <= ptjs_pkg::K_IDLE_SH;
         target_ff[ptjs_pkg::J_ELBOW]    <= ptjs_pkg::K_IDLE_EL;
         target_ff[ptjs_pkg::J_PITCH]    <= '0;
         target_ff[ptjs_pkg::J_ROLL]     <= '0;
         target_ff[ptjs_pkg::J_GRIP]     <= ptjs_pkg::K_HALF;
         smooth_ff[ptjs_pkg::J_YAW]      <= '0;
         smooth_ff[ptjs_pkg::J_SHOULDER] <= ptjs_pkg::K_FOLD_SH;
         smooth_ff[ptjs_pkg::J_ELBOW]    <= ptjs_pkg::K_FOLD_EL;
         smooth_ff[ptjs_pkg::J_PITCH]    <= '0;
         smooth_ff[ptjs_pkg::J_ROLL]     <= '0;
         smooth_ff[ptjs_pkg::J_GRIP]     <= ptjs_pkg::K_HALF;
         age_ff         <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               ptjs_pkg::CSR_ALPHA_ALIVE: alpha_alive_ff <= csr_wdata[12:0];
               ptjs_pkg::CSR_ALPHA_LOST:  alpha_lost_ff  <= csr_wdata[12:0];
               ptjs_pkg::CSR_TIMEOUT:     timeout_ff     <= csr_wdata[7:0];
               ptjs_pkg::CSR_IDLE_SH:     idle_sh_ff     <= csr_wdata;
               ptjs_pkg::CSR_IDLE_EL:     idle_el_ff     <= csr_wdata;
               ptjs_pkg::CSR_IDLE_GRIP:   idle_grip_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (req_acc) begin
            if (req_tuser == ptjs_pkg::OP_POSE) begin
               target_ff[ptjs_pkg::J_PITCH] <= tc;
               target_ff[ptjs_pkg::J_GRIP]  <= gc;
               age_ff <= '0;
            end else if (age_ff != ptjs_pkg::AGE_MAX) begin
               age_ff <= age_ff + 8'd1;
            end
         end
         if (ctl.wb) begin
            if (ctl.tick) begin
               smooth_ff[ctl.wb_idx] <= result;
            end else begin
               target_ff[ctl.wb_idx] <= result;
            end
         end
      end
   end

   // per-transaction operands
   always_ff @(posedge clock) begin
      if (req_acc) begin
         xm_ff    <= 18'(xc) - 18'(ptjs_pkg::K_HALF);
         lift_ff  <= 18'(ptjs_pkg::K_ONE) - 18'(yc);
         alive_ff <= alive_now;
         alpha_ff <= alive_now ? alpha_alive_ff : alpha_lost_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (ctl.load_rsp) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_rsp) begin
         rsp_data_ff <= {smooth_ff[ptjs_pkg::J_GRIP], smooth_ff[ptjs_pkg::J_ROLL],
                         smooth_ff[ptjs_pkg::J_PITCH], smooth_ff[ptjs_pkg::J_ELBOW],
                         smooth_ff[ptjs_pkg::J_SHOULDER], smooth_ff[ptjs_pkg::J_YAW]};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_pose_clears_age: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_tuser == ptjs_pkg::OP_POSE)) |=> (age_ff == 8'd0))
      else $error("pose age not cleared by a pose transaction");

   a_age_no_drop: assert property (@(posedge clock) disable iff (reset || $past(reset))
      !(req_acc && (req_tuser == ptjs_pkg::OP_POSE)) |=> (age_ff >= $past(age_ff)))
      else $error("pose age fell without a pose transaction");

   a_pose_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_tuser == ptjs_pkg::OP_POSE) && !rsp_tvalid_ff) |=> !rsp_tvalid_ff)
      else $error("pose transaction produced a result");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> out_free)
      else $error("result loaded over a stalled result");
`endif

endmodule
